>>> rtl/core/rc_pwm_pulse_capture_defines.svh
// Assertion helpers shared by the RC pulse capture RTL.
// Both forms sample on clk_i and stay quiet while rst_ni is low.
`ifndef RC_PWM_PULSE_CAPTURE_DEFINES_SVH
`define RC_PWM_PULSE_CAPTURE_DEFINES_SVH

// Plain property check.
`define RPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication check.
`define RPC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rpc_pkg.sv
`timescale 1ns / 1ps

package rpc_pkg;

  localparam int unsigned ChannelsDefault   = 8;
  localparam int unsigned CounterBitsDefault = 16;

  // Wide enough to compare any 3-bit channel number against up to 64 channels.
  localparam int unsigned ChanExtW = 7;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] MinWidthReset = 16'd500;
  localparam logic [15:0] MaxWidthReset = 16'd2500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_WIDTH = 1'b0,
    CFG_MAX_WIDTH = 1'b1
  } rpc_cfg_idx_e;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] capture_time;
  } rpc_in_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic        was_rising;
    logic        arm_falling;
    logic        new_pulse;
    logic [15:0] pulse_width;
    logic        signal_valid;
  } rpc_out_t;

  typedef struct packed {
    logic [15:0] min_width;
    logic [15:0] max_width;
  } rpc_cfg_t;

  // Handshake between the input hold register and the result stage.
  typedef struct packed {
    logic valid;    // hold register has a request
    logic advance;  // request moves into the result register this cycle
  } rpc_xfer_t;

endpackage

>>> rtl/core/rpc_in_reg.sv
`timescale 1ns / 1ps

module rpc_in_reg
  import rpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  rpc_in_t in_data_i,
  output logic    in_stall_o,
  input  logic    advance_i,
  output logic    hold_valid_o,
  output rpc_in_t hold_data_o
);

  logic    vld_d, vld_q;
  logic    load;
  rpc_in_t data_q;

  assign in_stall_o = vld_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign vld_d      = load | (vld_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign hold_valid_o = vld_q;
  assign hold_data_o  = data_q;

endmodule

>>> rtl/core/rpc_chan_state.sv
`timescale 1ns / 1ps

module rpc_chan_state
  import rpc_pkg::*;
#(
  parameter int unsigned CHANNELS     = ChannelsDefault,
  parameter int unsigned COUNTER_BITS = CounterBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rpc_cfg_t  cfg_i,
  input  rpc_xfer_t xfer_i,
  input  rpc_in_t   req_i,
  output rpc_out_t  res_o
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // Low COUNTER_BITS bits set; all ones once the counter covers the field.
  localparam logic [15:0] CntMask = 16'((64'd1 << COUNTER_BITS) - 64'd1);

  logic [15:0]         rise_q [CHANNELS];
  logic [15:0]         held_q [CHANNELS];
  logic [CHANNELS-1:0] exp_rise_q;
  logic [CHANNELS-1:0] seen_q;

  logic [ChanExtW-1:0] ch_ext;
  logic                in_range;
  logic [ChIdxW-1:0]   idx;
  logic [15:0]         cap;
  logic [15:0]         width;
  logic                exp_rise;
  logic                in_window;
  logic                upd;

  assign ch_ext   = ChanExtW'(req_i.channel);
  assign in_range = ch_ext < ChanExtW'(CHANNELS);
  assign idx      = ch_ext[ChIdxW-1:0];
  assign cap      = req_i.capture_time & CntMask;
  assign exp_rise = exp_rise_q[idx];
  // Unsigned wrap of the subtraction absorbs one counter rollover.
  assign width     = (cap - rise_q[idx]) & CntMask;
  assign in_window = (width >= cfg_i.min_width) && (width <= cfg_i.max_width);
  assign upd       = xfer_i.advance & in_range;

  always_comb begin
    res_o             = '0;
    res_o.out_channel = req_i.channel;
    if (in_range) begin
      res_o.was_rising   = exp_rise;
      res_o.arm_falling  = exp_rise;
      res_o.new_pulse    = ~exp_rise & in_window;
      res_o.pulse_width  = (~exp_rise & in_window) ? width : held_q[idx];
      res_o.signal_valid = seen_q[idx] | (~exp_rise & in_window);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_rise_q <= '1;
      seen_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        held_q[i] <= '0;
      end
    end else if (upd) begin
      exp_rise_q[idx] <= ~exp_rise;
      if (!exp_rise && in_window) begin
        held_q[idx] <= width;
        seen_q[idx] <= 1'b1;
      end
    end
  end

  // Only read after a rising edge has written it.
  always_ff @(posedge clk_i) begin
    if (upd && exp_rise) begin
      rise_q[idx] <= cap;
    end
  end

endmodule

>>> rtl/core/rpc_out_reg.sv
`timescale 1ns / 1ps

module rpc_out_reg
  import rpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     hold_valid_i,
  input  rpc_out_t res_i,
  output logic     advance_o,
  output logic     out_valid_o,
  output rpc_out_t out_data_o,
  input  logic     out_stall_i
);

  logic     vld_d, vld_q;
  rpc_out_t data_q;

  assign advance_o = hold_valid_i & (~vld_q | ~out_stall_i);
  assign vld_d     = advance_o | (vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/core/rc_pwm_pulse_capture.sv
`timescale 1ns / 1ps
// Path: an accepted request passes through the hold register, then the result register,
// where the result becomes valid; per-channel state updates as the request enters the result register.
// Throughput: one request per cycle while the result side is not stalled.
// A stalled result holds the result register; one more request still lands in the hold register.
// Reset (rst_ni low, async): every channel expects a rising edge, widths 0, valid flags clear;
// min_width = 500, max_width = 2500.
`include "rc_pwm_pulse_capture_defines.svh"

module rc_pwm_pulse_capture
  import rpc_pkg::*;
#(
  parameter int unsigned CHANNELS     = ChannelsDefault,
  parameter int unsigned COUNTER_BITS = CounterBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // capture event requests
  input  logic                in_valid_i,
  input  rpc_in_t             in_data_i,
  output logic                in_stall_o,
  // per-event results
  output logic                out_valid_o,
  output rpc_out_t            out_data_o,
  input  logic                out_stall_i,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Width window registers. The user must write them only while the block is idle; the block does not enforce it.
  rpc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width <= MinWidthReset;
      cfg_q.max_width <= MaxWidthReset;
    end else if (cfg_we_i) begin
      case (rpc_cfg_idx_e'(cfg_idx_i))
        CFG_MIN_WIDTH: cfg_q.min_width <= cfg_data_i;
        CFG_MAX_WIDTH: cfg_q.max_width <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpc_xfer_t xfer;
  logic      hold_valid;
  logic      advance;
  rpc_in_t   hold_data;
  rpc_out_t  res;

  assign xfer = '{valid: hold_valid, advance: advance};

  // Stage 1: request hold register. Also acts as the skid slot when the
  // result side is stalled.
  rpc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .advance_i    (advance),
    .hold_valid_o (hold_valid),
    .hold_data_o  (hold_data)
  );

  // Per-channel state: edge polarity, rise stamp, held width, sticky valid.
  // State commits in the same cycle the result is captured, so a following
  // request to the same channel sees the updated state.
  rpc_chan_state #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_chan_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .xfer_i (xfer),
    .req_i  (hold_data),
    .res_o  (res)
  );

  // Stage 2: result register toward the consumer.
  rpc_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_valid_i (hold_valid),
    .res_i        (res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_stall_i  (out_stall_i)
  );

  // A full hold register must back-pressure while the result side is blocked.
  `RPC_ASSERT_IMPL(a_full_blocks,
                   xfer.valid && out_valid_o && out_stall_i,
                   in_stall_o,
                   "hold register overrun")

  // Rising edge always arms the falling edge and vice versa.
  `RPC_ASSERT_IMPL(a_arm_matches,
                   out_valid_o,
                   out_data_o.was_rising == out_data_o.arm_falling,
                   "arm polarity mismatch")

  // A fresh pulse comes only from a falling edge and raises the sticky flag.
  `RPC_ASSERT_IMPL(a_new_pulse,
                   out_valid_o && out_data_o.new_pulse,
                   out_data_o.signal_valid && !out_data_o.was_rising,
                   "new pulse inconsistent")

  // Result register only loads when the hold register has a request.
  `RPC_ASSERT(a_adv_needs_req, !xfer.advance || xfer.valid, "advance without request")

endmodule
